FILE: src/kce_pkg.sv
// kce_pkg: shared types, constants and register indexes of the kirsch compass edge filter
// no dependencies

package kce_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_PIXEL_BITS = 16;

  // configuration register widths and reset values
  localparam int FW_BITS       = 12;
  localparam int FH_BITS       = 16;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam int MIN_DIM = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // ring of the eight neighbours, clockwise from top left
  localparam logic [1:0] RING_R [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
  localparam logic [1:0] RING_C [8] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};

  // per-window control passed from the line buffer to the core
  typedef struct packed {
    logic valid;
    logic last;
  } kce_ctrl_t;

endpackage

FILE: src/kirsch_compass_edge_filter.sv
// kirsch_compass_edge_filter: top level of the 3x3 kirsch compass edge filter
// after the input is accepted, a result passes the first stage, window, core sum and result registers
// throughput: one pixel per clock unless stalled; each line store takes one read and one write a cycle
// the whole pipeline stalls together only while a result waits at the output
// reset clears counters, window and valid flags and sets the frame size to 640x480
// line stores are not cleared; depends on kce_pkg, kce_line_buffer, kce_kirsch_core

module kirsch_compass_edge_filter import kce_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIXEL_BITS-1:0]   in_pixel_value,
  input  logic                    in_frame_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIXEL_BITS+3:0]   out_edge_strength,
  output logic                    out_frame_end,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wr_data
);

  logic                            advance;
  logic [FW_BITS-1:0]              frame_width_r;
  logic [FH_BITS-1:0]              frame_height_r;
  logic [2:0][2:0][PIXEL_BITS-1:0] win;
  kce_ctrl_t                       win_ctrl;

  // pipeline moves unless a result is held at the output
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wr_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  kce_line_buffer #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_line_buffer (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .in_valid       (in_valid),
    .in_pixel_value (in_pixel_value),
    .in_frame_start (in_frame_start),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .win_r          (win),
    .ctrl_r         (win_ctrl)
  );

  kce_kirsch_core #(.PIXEL_BITS(PIXEL_BITS)) u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .advance             (advance),
    .win                 (win),
    .ctrl                (win_ctrl),
    .out_valid_r         (out_valid),
    .out_edge_strength_r (out_edge_strength),
    .out_frame_end_r     (out_frame_end)
  );

endmodule

FILE: src/kce_ram.sv
// kce_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module kce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: src/kce_line_buffer.sv
// kce_line_buffer: raster position counters, two line stores and the 3x3 window
// depends on kce_pkg and kce_ram

module kce_line_buffer import kce_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               in_valid,
  input  logic [PIXEL_BITS-1:0]              in_pixel_value,
  input  logic                               in_frame_start,
  input  logic [FW_BITS-1:0]                 frame_width,
  input  logic [FH_BITS-1:0]                 frame_height,
  output logic [2:0][2:0][PIXEL_BITS-1:0]    win_r,
  output kce_ctrl_t                          ctrl_r
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;
  localparam int RW = FH_BITS + 1;

  logic              accept;
  logic [CW-1:0]     col_r, col_nxt, col_cur;
  logic [FH_BITS-1:0] row_r, row_nxt, row_cur;
  logic [EW-1:0]     eff_w, col_inc;
  logic [RW-1:0]     eff_h, row_inc;
  logic              emit, last;

  logic                  s1_valid_r, s1_emit_r, s1_last_r;
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic [CW-1:0]         s1_col_r;
  logic                  byp_r, byp_nxt;
  logic [PIXEL_BITS-1:0] byp_a_r, byp_b_r;
  logic [PIXEL_BITS-1:0] rd_a, rd_b, up1, up2;
  logic                  wr_en;

  assign accept = in_valid && advance;

  // effective frame size, clamped to the supported range
  always_comb begin
    eff_w = EW'(frame_width);
    if (eff_w < EW'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (eff_w > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end
    eff_h = RW'(frame_height);
    if (eff_h < RW'(MIN_DIM)) begin
      eff_h = RW'(MIN_DIM);
    end
  end

  // position of the incoming pixel and of the one after it
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? '0 : row_r;
    col_inc = EW'(col_cur) + EW'(1);
    row_inc = RW'(row_cur) + RW'(1);
    emit    = (row_cur >= FH_BITS'(2)) && (col_cur >= CW'(2));
    last    = (RW'(row_cur) == eff_h - RW'(1)) && (EW'(col_cur) == eff_w - EW'(1));
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eff_h) ? '0 : row_inc[FH_BITS-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // same column written back by the item ahead: forward its data
  assign byp_nxt = s1_valid_r && (col_cur == s1_col_r);
  assign up1     = byp_r ? byp_a_r : rd_a;
  assign up2     = byp_r ? byp_b_r : rd_b;
  assign wr_en   = s1_valid_r && advance;

  // line store a holds the previous row, b the row before it
  kce_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (s1_col_r),
    .wdata   (s1_px_r),
    .re      (advance),
    .raddr   (col_cur),
    .rdata_r (rd_a)
  );

  kce_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (s1_col_r),
    .wdata   (up1),
    .re      (advance),
    .raddr   (col_cur),
    .rdata_r (rd_b)
  );

  // first stage: pixel and position while the line stores are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      byp_r      <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px_r   <= in_pixel_value;
      s1_col_r  <= col_cur;
      s1_emit_r <= emit;
      s1_last_r <= last;
      byp_a_r   <= s1_px_r;
      byp_b_r   <= up1;
    end
  end

  // window shift: oldest row on top, newest column on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= s1_px_r;
    end
  end

  // window control: only interior centres go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (advance) begin
      ctrl_r.valid <= s1_valid_r && s1_emit_r;
      ctrl_r.last  <= s1_last_r;
    end
  end

endmodule

FILE: src/kce_kirsch_core.sv
// kce_kirsch_core: maximum of the eight compass responses as 8*S - 3*T, two stages
// depends on kce_pkg

module kce_kirsch_core import kce_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic [2:0][2:0][PIXEL_BITS-1:0] win,
  input  kce_ctrl_t                       ctrl,
  output logic                            out_valid_r,
  output logic [PIXEL_BITS+3:0]           out_edge_strength_r,
  output logic                            out_frame_end_r
);

  localparam int SW = PIXEL_BITS + 2;
  localparam int TW = PIXEL_BITS + 3;
  localparam int OW = PIXEL_BITS + 4;
  localparam int XW = PIXEL_BITS + 5;

  logic [PIXEL_BITS-1:0] v [8];
  logic [SW-1:0]         s3 [8];
  logic [SW-1:0]         m4 [4];
  logic [SW-1:0]         m2 [2];
  logic [SW-1:0]         best;
  logic [TW-1:0]         total;
  kce_ctrl_t             ctrl_s_r;
  logic [SW-1:0]         best_r;
  logic [TW-1:0]         total_r;
  logic [XW-1:0]         result;

  // ring values, triple sums, their maximum and the ring total
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      v[k] = win[RING_R[k]][RING_C[k]];
    end
    for (int k = 0; k < 8; k++) begin
      s3[k] = SW'(v[k]) + SW'(v[(k + 1) % 8]) + SW'(v[(k + 2) % 8]);
    end
    for (int k = 0; k < 4; k++) begin
      m4[k] = (s3[2*k] > s3[2*k+1]) ? s3[2*k] : s3[2*k+1];
    end
    for (int k = 0; k < 2; k++) begin
      m2[k] = (m4[2*k] > m4[2*k+1]) ? m4[2*k] : m4[2*k+1];
    end
    best  = (m2[0] > m2[1]) ? m2[0] : m2[1];
    total = ((TW'(v[0]) + TW'(v[1])) + (TW'(v[2]) + TW'(v[3])))
          + ((TW'(v[4]) + TW'(v[5])) + (TW'(v[6]) + TW'(v[7])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_s_r <= '0;
    end else if (advance) begin
      ctrl_s_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      best_r  <= best;
      total_r <= total;
    end
  end

  // final response, never negative
  assign result = (XW'(best_r) << 3) - (XW'(total_r) + (XW'(total_r) << 1));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ctrl_s_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_edge_strength_r <= result[OW-1:0];
      out_frame_end_r     <= ctrl_s_r.last;
    end
  end

endmodule

FILE: src/kce_checker.sv
// kce_checker: port-level assertions for the kirsch compass edge filter, with its bind
// depends on kce_pkg and kirsch_compass_edge_filter

module kce_checker import kce_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PIXEL_BITS+3:0] out_edge_strength,
  input logic                  out_frame_end
);

  // input is held off only while a result is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no blocked result");

  // a result that is taken never stalls the input
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("input stalled while result is taken");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_edge_strength) && $stable(out_frame_end)))
    else $error("stalled result changed");

endmodule

bind kirsch_compass_edge_filter kce_checker #(.PIXEL_BITS(PIXEL_BITS)) u_kce_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_edge_strength (out_edge_strength),
  .out_frame_end     (out_frame_end)
);
